// File: design/emgbh_pkg.sv
// ----------------------------------------------------------------------------
// emgbh_pkg
// Shared types and constants of the EMG baseline and hysteresis detector.
// ----------------------------------------------------------------------------
package emgbh_pkg;

  localparam int CALIB_COUNT_DEF = 512;

  localparam int          APB_AW     = 4;
  localparam logic [15:0] ALPHA_RST  = 16'd6554;
  localparam logic [15:0] ENGAGE_RST = 16'd768;
  localparam logic [15:0] RELEASE_RST = 16'd384;

  // register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_ALPHA   = 2'd0,
    REG_ENGAGE  = 2'd1,
    REG_RELEASE = 2'd2,
    REG_NONE    = 2'd3
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_WEIGHT,
    ST_BLEND,
    ST_ROOT,
    ST_STORE,
    ST_SORT_KEY,
    ST_SORT_CMP,
    ST_SORT_PLACE,
    ST_SUM,
    ST_MEAN,
    ST_PREP,
    ST_RATIO,
    ST_RESULT
  } state_e;

endpackage

// File: design/emgbh_ram.sv
// ----------------------------------------------------------------------------
// emgbh_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module emgbh_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/emgbh_sqrt.sv
// ----------------------------------------------------------------------------
// emgbh_sqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module emgbh_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] operand_i,
  output logic        done_o,
  output logic [15:0] root_o
);

  logic [31:0] v_q, v_d;
  logic [31:0] root_q, root_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [31:0] bitv;
  logic [32:0] trial;

  always_comb begin
    bitv   = 32'd1 << {cnt_q, 1'b0};
    trial  = {1'b0, root_q} + {1'b0, bitv};
    v_d    = v_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      v_d    = operand_i;
      root_d = '0;
      cnt_d  = 4'd15;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if ({1'b0, v_q} >= trial) begin
        v_d    = v_q - trial[31:0];
        root_d = (root_q >> 1) + bitv;
      end else begin
        root_d = root_q >> 1;
      end
      cnt_d = cnt_q - 4'd1;
      if (cnt_q == 4'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q    <= v_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q[15:0];

endmodule

// File: design/emgbh_div.sv
// ----------------------------------------------------------------------------
// emgbh_div
// Restoring divider by a 16-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module emgbh_div #(
  parameter int DVW = 25
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [DVW-1:0] dividend_i,
  input  logic [15:0]    divisor_i,
  output logic           done_o,
  output logic [DVW-1:0] quot_o
);

  localparam int CNW = $clog2(DVW + 1);

  logic [DVW-1:0] dvd_q, dvd_d;
  logic [15:0]    rem_q, rem_d;
  logic [15:0]    dsr_q, dsr_d;
  logic [CNW-1:0] cnt_q, cnt_d;
  logic           busy_q, busy_d;
  logic           done_q, done_d;
  logic [16:0]    trial;
  logic           qbit;

  always_comb begin
    trial  = {rem_q, dvd_q[DVW-1]};
    qbit   = trial >= {1'b0, dsr_q};
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
      cnt_d  = CNW'(DVW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = qbit ? 16'(trial - {1'b0, dsr_q}) : trial[15:0];
      dvd_d = {dvd_q[DVW-2:0], qbit};
      cnt_d = cnt_q - CNW'(1);
      if (cnt_q == CNW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule

// File: design/emg_baseline_hysteresis_detector.sv
// ----------------------------------------------------------------------------
// emg_baseline_hysteresis_detector
// EMG RMS envelope with calibrated baseline, Q8.8 ratio and hysteresis flag.
// ----------------------------------------------------------------------------
// One sample word is taken at a time. A sample passes through the EMA
// arithmetic, the bit-serial square root and, once calibrated, the shared
// serial divider. Calibration words give no result. After the last
// calibration word the RAM holding the stored RMS values is insertion
// sorted in place (one element move at a time, bounded by the single read
// and write port), summed and divided; no sample is taken during that
// time. Register writes are taken at any time.
module emg_baseline_hysteresis_detector
  import emgbh_pkg::*;
#(
  parameter int CALIB_COUNT = CALIB_COUNT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic signed [15:0] emg_sample_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [15:0]       rms_level_o,
  output logic [15:0]       level_ratio_o,
  output logic              hand_closed_o
);

  localparam int AW   = $clog2(CALIB_COUNT);
  localparam int CW   = $clog2(CALIB_COUNT + 1);
  localparam int KEEP = (CALIB_COUNT * 4) / 5;
  localparam int SW   = AW + 16;
  localparam int DVW  = (SW > 24) ? SW : 24;

  // configuration
  logic [15:0] alpha_q, engage_q, release_q;
  logic        cfg_we;
  reg_idx_e    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q   <= ALPHA_RST;
      engage_q  <= ENGAGE_RST;
      release_q <= RELEASE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_ALPHA:   alpha_q   <= pwdata[15:0];
        REG_ENGAGE:  engage_q  <= pwdata[15:0];
        REG_RELEASE: release_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ALPHA:   prdata = {16'd0, alpha_q};
      REG_ENGAGE:  prdata = {16'd0, engage_q};
      REG_RELEASE: prdata = {16'd0, release_q};
      default:     prdata = '0;
    endcase
  end

  // datapath and control
  state_e           state_q, state_d;
  logic [15:0]      sample_q, sample_d;
  logic [31:0]      sq_q, sq_d;
  logic [47:0]      p1_q, p1_d;
  logic [31:0]      ms_q, ms_d;
  logic [15:0]      rms_q, rms_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             cal_q, cal_d;
  logic [15:0]      base_q, base_d;
  logic             closed_q, closed_d;
  logic [15:0]      key_q, key_d;
  logic [CW-1:0]    i_q, i_d;
  logic [AW-1:0]    j_q, j_d;
  logic [CW-1:0]    k_q, k_d;
  logic [SW-1:0]    sum_q, sum_d;
  logic [31:0]      eng_q, eng_d, rel_q, rel_d;
  logic [15:0]      ratio_q, ratio_d;
  logic             ov_q, ov_d;
  logic [15:0]      orms_q, orms_d, oratio_q, oratio_d;
  logic             oclosed_q, oclosed_d;

  logic [15:0]      mag;
  logic [48:0]      acc;
  logic [CW-1:0]    i_nx;
  logic [23:0]      scaled;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [15:0]      ram_wdata, ram_rdata;

  logic             sq_start, sq_done;
  logic [15:0]      sq_root;
  logic             dv_start, dv_done;
  logic [DVW-1:0]   dv_dividend, dv_quot;
  logic [15:0]      dv_divisor;

  emgbh_ram #(.WIDTH(16), .DEPTH(CALIB_COUNT)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  emgbh_sqrt u_sqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (sq_start),
    .operand_i (ms_d),
    .done_o    (sq_done),
    .root_o    (sq_root)
  );

  emgbh_div #(.DVW(DVW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (dv_start),
    .dividend_i (dv_dividend),
    .divisor_i  (dv_divisor),
    .done_o     (dv_done),
    .quot_o     (dv_quot)
  );

  always_comb begin
    mag    = sample_q[15] ? 16'(17'h10000 - {1'b0, sample_q}) : sample_q;
    acc    = {1'b0, p1_q} + ({32'd0, 17'h10000 - {1'b0, alpha_q}} * {17'd0, ms_q});
    i_nx   = i_q + CW'(1);
    scaled = {rms_q, 8'd0};

    state_d   = state_q;
    sample_d  = sample_q;
    sq_d      = sq_q;
    p1_d      = p1_q;
    ms_d      = ms_q;
    rms_d     = rms_q;
    cnt_d     = cnt_q;
    cal_d     = cal_q;
    base_d    = base_q;
    closed_d  = closed_q;
    key_d     = key_q;
    i_d       = i_q;
    j_d       = j_q;
    k_d       = k_q;
    sum_d     = sum_q;
    eng_d     = eng_q;
    rel_d     = rel_q;
    ratio_d   = ratio_q;
    orms_d    = orms_q;
    oratio_d  = oratio_q;
    oclosed_d = oclosed_q;
    ov_d      = ov_q && out_stall_i;

    in_stall_o  = 1'b1;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = rms_q;
    ram_raddr   = '0;
    sq_start    = 1'b0;
    dv_start    = 1'b0;
    dv_dividend = DVW'(scaled);
    dv_divisor  = base_q;

    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          sample_d = emg_sample_i;
          state_d  = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        sq_d    = {16'd0, mag} * {16'd0, mag};
        state_d = ST_WEIGHT;
      end
      ST_WEIGHT: begin
        p1_d    = {32'd0, alpha_q} * {16'd0, sq_q};
        state_d = ST_BLEND;
      end
      ST_BLEND: begin
        ms_d     = acc[47:16];
        sq_start = 1'b1;
        state_d  = ST_ROOT;
      end
      ST_ROOT: begin
        if (sq_done) begin
          rms_d   = sq_root;
          state_d = cal_q ? ST_PREP : ST_STORE;
        end
      end
      ST_STORE: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q[AW-1:0];
        cnt_d     = cnt_q + CW'(1);
        if (cnt_q + CW'(1) == CW'(CALIB_COUNT)) begin
          i_d       = CW'(1);
          ram_raddr = AW'(1);
          state_d   = ST_SORT_KEY;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SORT_KEY: begin
        key_d     = ram_rdata;
        j_d       = i_q[AW-1:0];
        ram_raddr = i_q[AW-1:0] - AW'(1);
        state_d   = ST_SORT_CMP;
      end
      ST_SORT_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = j_q;
        if (ram_rdata > key_q) begin
          // shift the larger entry up one place
          ram_wdata = ram_rdata;
          if (j_q == AW'(1)) begin
            state_d = ST_SORT_PLACE;
          end else begin
            j_d       = j_q - AW'(1);
            ram_raddr = j_q - AW'(2);
          end
        end else begin
          ram_wdata = key_q;
          i_d       = i_nx;
          if (i_nx == CW'(CALIB_COUNT)) begin
            k_d     = '0;
            sum_d   = '0;
            state_d = ST_SUM;
          end else begin
            ram_raddr = i_nx[AW-1:0];
            state_d   = ST_SORT_KEY;
          end
        end
      end
      ST_SORT_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = key_q;
        i_d       = i_nx;
        if (i_nx == CW'(CALIB_COUNT)) begin
          k_d     = '0;
          sum_d   = '0;
          state_d = ST_SUM;
        end else begin
          ram_raddr = i_nx[AW-1:0];
          state_d   = ST_SORT_KEY;
        end
      end
      ST_SUM: begin
        // read address k, add the word read at the previous address
        ram_raddr = k_q[AW-1:0];
        if (k_q != '0) begin
          sum_d = sum_q + {{(SW-16){1'b0}}, ram_rdata};
        end
        k_d = k_q + CW'(1);
        if (k_q == CW'(KEEP)) begin
          dv_start    = 1'b1;
          dv_dividend = DVW'(sum_d);
          dv_divisor  = 16'(KEEP);
          state_d     = ST_MEAN;
        end
      end
      ST_MEAN: begin
        if (dv_done) begin
          base_d  = dv_quot[15:0];
          cal_d   = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_PREP: begin
        eng_d = {16'd0, base_q} * {16'd0, engage_q};
        rel_d = {16'd0, base_q} * {16'd0, release_q};
        if (base_q == '0) begin
          ratio_d = 16'hFFFF;
          state_d = ST_RESULT;
        end else begin
          dv_start = 1'b1;
          state_d  = ST_RATIO;
        end
      end
      ST_RATIO: begin
        if (dv_done) begin
          ratio_d = (|dv_quot[DVW-1:16]) ? 16'hFFFF : dv_quot[15:0];
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        // hold until the output register is free
        if (!ov_q || !out_stall_i) begin
          if (!closed_q && ({8'd0, scaled} > eng_q)) begin
            closed_d = 1'b1;
          end else if (closed_q && ({8'd0, scaled} < rel_q)) begin
            closed_d = 1'b0;
          end
          orms_d    = rms_q;
          oratio_d  = ratio_q;
          oclosed_d = closed_d;
          ov_d      = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ms_q     <= '0;
      cnt_q    <= '0;
      cal_q    <= 1'b0;
      base_q   <= '0;
      closed_q <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      ms_q     <= ms_d;
      cnt_q    <= cnt_d;
      cal_q    <= cal_d;
      base_q   <= base_d;
      closed_q <= closed_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q  <= sample_d;
    sq_q      <= sq_d;
    p1_q      <= p1_d;
    rms_q     <= rms_d;
    key_q     <= key_d;
    i_q       <= i_d;
    j_q       <= j_d;
    k_q       <= k_d;
    sum_q     <= sum_d;
    eng_q     <= eng_d;
    rel_q     <= rel_d;
    ratio_q   <= ratio_d;
    orms_q    <= orms_d;
    oratio_q  <= oratio_d;
    oclosed_q <= oclosed_d;
  end

  assign out_valid_o   = ov_q;
  assign rms_level_o   = orms_q;
  assign level_ratio_o = oratio_q;
  assign hand_closed_o = oclosed_q;

  // assertions
  a_cal_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cal_q |-> cnt_q == CW'(CALIB_COUNT))
    else $error("calibrated with store not full");

  a_result_after_cal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ov_q) |-> cal_q)
    else $error("result word before calibration");

  a_sort_no_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && state_q == ST_SORT_CMP && ram_rdata > key_q && j_q != AW'(1))
      |-> ram_waddr != ram_raddr)
    else $error("sort reads and writes the same entry");

  a_root_in_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_done |-> state_q == ST_ROOT)
    else $error("square root finished outside its state");

endmodule

// File: dv/emg_baseline_hysteresis_detector_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// emg_baseline_hysteresis_detector_tb
// Self-checking bench for the EMG envelope detector: an envelope predictor
// follows every accepted sample word, result words are compared field by
// field in order, with random idling on both channels and register phases.
// ----------------------------------------------------------------------------
module emg_baseline_hysteresis_detector_tb;
  import emgbh_pkg::*;

  localparam int  CAL_WORDS   = CALIB_COUNT_DEF;
  localparam int  CYCLE_LIMIT = 4000000;
  localparam int  DRAIN_WAIT  = 120;

  typedef struct packed {
    logic [15:0] rms;
    logic [15:0] ratio;
    logic        closed;
  } envelope_t;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_TYPED} row_kind_e;

  typedef struct {
    logic signed [15:0] sample;
    row_kind_e          kind;
    envelope_t          typed;
  } stim_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic signed [15:0] emg_sample_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [15:0]       rms_level_o, level_ratio_o;
  logic              hand_closed_o;

  // predictor state
  logic [15:0]  alpha_q = ALPHA_RST, engage_q = ENGAGE_RST, release_q = RELEASE_RST;
  logic [31:0]  mean_sq = '0;
  int unsigned  cal_levels[$];
  bit           calibrated = 1'b0;
  logic [15:0]  baseline = '0;
  bit           closed = 1'b0;

  envelope_t    pending_env[$];
  int           n_errors = 0;
  int           n_words = 0;
  int           n_results = 0;
  int           n_closed = 0;
  longint       cycles = 0;
  bit           hold_req = 1'b0;
  bit           no_idle = 1'b0;
  bit           offer_open = 1'b0;

  emg_baseline_hysteresis_detector DUT (.*);

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout after %0d cycles", $time, cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [15:0] root_floor(input logic [31:0] v);
    logic [15:0] r;
    logic [16:0] trial;
    r = '0;
    for (int b = 15; b >= 0; b--) begin
      trial = {1'b0, r} | (17'd1 << b);
      if (64'(trial) * 64'(trial) <= 64'(v)) r = trial[15:0];
    end
    return r;
  endfunction

  // advance the envelope by one sample; returns 1 when a result word follows
  function automatic bit envelope_step(input logic signed [15:0] s, output envelope_t r);
    longint unsigned mag, acc, scaled, q;
    logic [15:0] rms;
    longint unsigned total;
    int keep;
    mag = (s < 0) ? longint'(-int'(s)) : longint'(s);
    acc = 64'(alpha_q) * mag * mag + (64'd65536 - 64'(alpha_q)) * 64'(mean_sq);
    mean_sq = acc[47:16];
    rms = root_floor(mean_sq);
    r = '0;
    if (!calibrated) begin
      cal_levels.insert(cal_levels.size(), rms);
      if (cal_levels.size() >= CAL_WORDS) begin
        cal_levels.sort();
        keep = (CAL_WORDS * 4) / 5;
        total = 0;
        for (int i = 0; i < keep; i++) total += cal_levels[i];
        baseline = keep ? 16'(total / keep) : '0;
        calibrated = 1'b1;
      end
      return 1'b0;
    end
    scaled = 64'(rms) << 8;
    if (baseline == 0) r.ratio = 16'hFFFF;
    else begin
      q = scaled / baseline;
      r.ratio = (q > 65535) ? 16'hFFFF : q[15:0];
    end
    if (!closed && scaled > 64'(baseline) * 64'(engage_q)) closed = 1'b1;
    else if (closed && scaled < 64'(baseline) * 64'(release_q)) closed = 1'b0;
    r.rms = rms;
    r.closed = closed;
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (no_idle || r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic reg_write(input reg_idx_e idx, input logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= APB_AW'(idx) << 2; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_ALPHA:   alpha_q = val[15:0];
      REG_ENGAGE:  engage_q = val[15:0];
      REG_RELEASE: release_q = val[15:0];
      default: ;
    endcase
  endtask

  // offer one sample word, hold it until taken, then predict
  task automatic send_sample(input logic signed [15:0] s, input bit use_typed,
                             input envelope_t typed);
    envelope_t e;
    int gap;
    offer_open = 1'b0;
    in_valid_i <= 1'b1;
    emg_sample_i <= s;
    do @(posedge clk_i); while (in_stall_o);
    n_words++;
    if (envelope_step(s, e)) pending_env.insert(pending_env.size(), use_typed ? typed : e);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      emg_sample_i <= 16'($urandom);
      repeat (gap) @(posedge clk_i);
    end else begin
      offer_open = 1'b1;
    end
  endtask

  // drop valid right after the last accepted word so it is not offered again
  task automatic close_offer();
    if (offer_open) begin
      in_valid_i <= 1'b0;
      offer_open = 1'b0;
    end
  endtask

  task automatic settle();
    close_offer();
    wait (pending_env.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  // bursts, baseline-level noise, quiet stretches and a little pure noise
  task automatic run_sequences(input int n_items);
    int mode, len, lo, hi, sent;
    logic signed [15:0] s;
    envelope_t none;
    none = '0;
    sent = 0;
    while (sent < n_items) begin
      mode = $urandom_range(0, 9);
      len = $urandom_range(5, 15);
      if (mode < 3) begin lo = 2000; hi = 32767; end
      else if (mode < 6) begin lo = 0; hi = 300; end
      else begin lo = 0; hi = 20; end
      for (int k = 0; k < len && sent < n_items; k++) begin
        s = (mode == 9) ? 16'($urandom) : 16'($urandom_range(lo, hi));
        if (mode != 9 && $urandom_range(0, 1)) s = -s;
        send_sample(s, 1'b0, none);
        sent++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    envelope_t got, want;
    if (out_valid_o && !out_stall_i) begin
      got = '{rms: rms_level_o, ratio: level_ratio_o, closed: hand_closed_o};
      n_results++;
      if (hand_closed_o) n_closed++;
      if (pending_env.size() == 0) begin
        n_errors++;
        $display("%0t unexpected word: rms %0d ratio %0d closed %0b", $time,
                 got.rms, got.ratio, got.closed);
      end else begin
        want = pending_env.pop_front();
        if (got.rms !== want.rms || got.ratio !== want.ratio
            || got.closed !== want.closed) begin
          n_errors++;
          $display("%0t mismatch: expected rms %0d ratio %0d closed %0b, got rms %0d ratio %0d closed %0b",
                   $time, want.rms, want.ratio, want.closed,
                   got.rms, got.ratio, got.closed);
        end
      end
    end
  end

  // receiver: random stalls, and one long hold-off on request
  initial begin
    int r;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (400) @(posedge clk_i);
      end else begin
        r = $urandom_range(0, 19);
        if (no_idle || r < 12) out_stall_i <= 1'b0;
        else if (r < 18) begin
          out_stall_i <= 1'b1;
          repeat ($urandom_range(0, 2)) @(posedge clk_i);
        end else begin
          out_stall_i <= 1'b1;
          repeat ($urandom_range(10, 60)) @(posedge clk_i);
        end
      end
    end
  end

  initial begin
    stim_row_t rows[$];
    envelope_t none;
    logic signed [15:0] s;
    none = '0;
    // calibration words: no result, not even for the last
    rows.insert(rows.size(), '{16'sh8000, ROW_PREDICT, none});
    rows.insert(rows.size(), '{16'sh7FFF, ROW_PREDICT, none});
    rows.insert(rows.size(), '{16'sh0000, ROW_PREDICT, none});
    rows.insert(rows.size(), '{-16'sd1, ROW_PREDICT, none});
    rows.insert(rows.size(), '{16'sd1, ROW_PREDICT, none});
    rows.insert(rows.size(), '{16'sh5555, ROW_PREDICT, none});
    rows.insert(rows.size(), '{16'shAAAA, ROW_PREDICT, none});
    // after calibration, alpha at its top: ratio saturates on a full-scale word
    rows.insert(rows.size(), '{16'sh7FFF, ROW_PREDICT, none});
    rows.insert(rows.size(), '{16'sh8000, ROW_PREDICT, none});
    rows.insert(rows.size(), '{16'sh0000, ROW_PREDICT, none});
    // two silent words leave rms 0, ratio 0, and the flag released
    rows.insert(rows.size(),
                '{16'sh0000, ROW_TYPED, '{rms: 16'd0, ratio: 16'd0, closed: 1'b0}});
    rows.insert(rows.size(), '{16'sd1, ROW_PREDICT, none});
    rows.insert(rows.size(), '{-16'sd1, ROW_PREDICT, none});
    rows.insert(rows.size(), '{16'sh5555, ROW_PREDICT, none});
    rows.insert(rows.size(), '{16'shAAAA, ROW_PREDICT, none});
    rows.insert(rows.size(), '{16'sd200, ROW_PREDICT, none});
    rows.insert(rows.size(), '{-16'sd200, ROW_PREDICT, none});
    rows.insert(rows.size(), '{16'sh0000, ROW_PREDICT, none});

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);
    reg_write(REG_ALPHA, 32'h0000_FFFF);
    reg_write(REG_ENGAGE, 32'hABCD_0300);  // upper half dropped
    reg_write(REG_RELEASE, 32'd384);
    reg_write(REG_NONE, 32'h0000_0001);    // ignored

    for (int i = 0; i < rows.size(); i++) begin
      if (i == 7) begin
        // fill the calibration store with moderate noise
        for (int k = 7; k < CAL_WORDS; k++) begin
          s = 16'($urandom_range(20, 200));
          if ($urandom_range(0, 1)) s = -s;
          send_sample(s, 1'b0, none);
        end
      end
      send_sample(rows[i].sample, rows[i].kind == ROW_TYPED, rows[i].typed);
    end
    settle();

    // phase: reset-like smoothing
    reg_write(REG_ALPHA, 32'd6554);
    reg_write(REG_ENGAGE, 32'd768);
    reg_write(REG_RELEASE, 32'd384);
    run_sequences(60);
    settle();

    // phase: receiver holds off while the sender keeps offering
    reg_write(REG_ALPHA, 32'd65535);
    reg_write(REG_ENGAGE, 32'd0);
    reg_write(REG_RELEASE, 32'd0);
    hold_req = 1'b1;
    run_sequences(50);
    settle();

    // phase: slowest average, unreachable thresholds; sender pauses midway
    reg_write(REG_ALPHA, 32'd1);
    reg_write(REG_ENGAGE, 32'd65535);
    reg_write(REG_RELEASE, 32'd65535);
    run_sequences(25);
    close_offer();
    wait (pending_env.size() == 0);
    run_sequences(25);
    settle();

    // phase: back-to-back, moderate thresholds
    no_idle = 1'b1;
    reg_write(REG_ALPHA, 32'd32768);
    reg_write(REG_ENGAGE, 32'd512);
    reg_write(REG_RELEASE, 32'd256);
    run_sequences(50);
    settle();
    no_idle = 1'b0;

    // phase: random settings
    reg_write(REG_ALPHA, 32'($urandom_range(1, 65535)));
    reg_write(REG_ENGAGE, 32'($urandom_range(256, 2048)));
    reg_write(REG_RELEASE, 32'($urandom_range(0, 512)));
    run_sequences(60);

    close_offer();
    wait (pending_env.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("%0d sample words taken, %0d result words checked (%0d closed)",
             n_words, n_results, n_closed);
    $display("calibration to baseline %0d, six register settings incl. extremes", baseline);
    if (n_errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// File: files.f
design/emgbh_pkg.sv
design/emgbh_ram.sv
design/emgbh_sqrt.sv
design/emgbh_div.sv
design/emg_baseline_hysteresis_detector.sv
dv/emg_baseline_hysteresis_detector_tb.sv
